FILE: sv/rtp_pkg.sv
// shared types and constants of the relay time-proportioning pwm
// no dependencies, compile first
package rtp_pkg;

    typedef logic [31:0] stamp_t;
    typedef logic [15:0] ms16_t;
    typedef logic [13:0] duty_t;
    typedef logic [29:0] prod_t;
    typedef logic [6:0]  pct_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CYCLE_LENGTH  = 3'd0,
        CFG_MIN_DUTY      = 3'd1,
        CFG_SAMPLE_PERIOD = 3'd2,
        CFG_MANUAL_MODE   = 3'd3,
        CFG_MANUAL_POWER  = 3'd4
    } cfg_index_t;

    // full scale duty, hundredths of a percent
    localparam duty_t FULL_DUTY = 14'd10000;
    localparam prod_t FULL_PROD = 30'd10000;
    localparam duty_t PCT_SCALE = 14'd100;

    // floor(2^30 / 10000): quotient estimate is exact or one low
    localparam int unsigned RECIP_SHIFT = 30;
    localparam logic [16:0] RECIP_MULT  = 17'd107374;

    // register reset values
    localparam ms16_t CYCLE_LENGTH_RST  = 16'd10000;
    localparam duty_t MIN_DUTY_RST      = 14'd500;
    localparam duty_t SAMPLE_PERIOD_RST = 14'd100;

    typedef struct packed {
        logic heater_on;
        logic cycle_started;
        logic output_sampled;
    } rtp_flags_t;

endpackage

FILE: sv/rtp_in_if.sv
// input item channel: timestamp and controller output
// depends on rtp_pkg
interface rtp_in_if;
    import rtp_pkg::*;

    logic   valid;
    logic   ready;
    stamp_t now_ms;
    duty_t  ctrl_output;

    modport source (output valid, output now_ms, output ctrl_output, input ready);
    modport sink (input valid, input now_ms, input ctrl_output, output ready);
endinterface

FILE: sv/rtp_out_if.sv
// result channel: relay level, cycle start, on-time, sample flag
// depends on rtp_pkg
interface rtp_out_if;
    import rtp_pkg::*;

    logic  valid;
    logic  ready;
    logic  heater_on;
    logic  cycle_started;
    ms16_t on_time_ms;
    logic  output_sampled;

    modport source (output valid, output heater_on, output cycle_started,
                    output on_time_ms, output output_sampled, input ready);
    modport sink (input valid, input heater_on, input cycle_started,
                  input on_time_ms, input output_sampled, output ready);
endinterface

FILE: sv/rtp_cfg_if.sv
// configuration write channel: register index and write data
// depends on rtp_pkg
interface rtp_cfg_if;
    import rtp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/relay_time_proportioning_pwm_top.sv
// relay time-proportioning pwm, top level
// depends on rtp_pkg, rtp_in_if, rtp_out_if, rtp_cfg_if
//
// result path: an accepted item passes the s1, s2 and out registers, in that order, before it is valid
// throughput: one item per cycle while result.ready does not stall the pipeline; the per-item state loop (duty select,
//   min-duty rounding, 14x16 on-product multiply, on-time compare) has no register inside it
// reset: asynchronous active low; configuration, state and valid registers take their reset values, relay off
module relay_time_proportioning_pwm_top (
    input  logic       clk,
    input  logic       rst_n,
    rtp_in_if.sink     item,
    rtp_cfg_if.sink    cfg,
    rtp_out_if.source  result
);
    import rtp_pkg::*;

    // configuration registers
    ms16_t cycle_len_reg;
    duty_t min_duty_reg;
    duty_t sample_period_reg;
    logic  manual_reg;
    pct_t  manual_pct_reg;

    // block state; the on-time is held as its undivided product duty * cycle
    stamp_t cycle_start_reg;
    stamp_t last_sample_reg;
    duty_t  pending_reg;
    prod_t  prod_reg;
    logic   relay_reg;

    // result pipeline
    logic       s1_valid_reg, s2_valid_reg, out_valid_reg;
    prod_t      s1_prod_reg, s2_prod_reg;
    rtp_flags_t s1_flags_reg, s2_flags_reg, out_flags_reg;
    ms16_t      s2_quot_reg;
    ms16_t      out_on_time_reg;

    // config writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_len_reg     <= CYCLE_LENGTH_RST;
            min_duty_reg      <= MIN_DUTY_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            manual_reg        <= 1'b0;
            manual_pct_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_CYCLE_LENGTH:  cycle_len_reg     <= cfg.data;
                CFG_MIN_DUTY:      min_duty_reg      <= cfg.data[13:0];
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg.data[13:0];
                CFG_MANUAL_MODE:   manual_reg        <= cfg.data[0];
                CFG_MANUAL_POWER:  manual_pct_reg    <= cfg.data[6:0];
                default:           ;
            endcase
        end
    end

    // pipeline handshake: each stage moves when the one after it can take data
    logic out_adv, s2_ready, s1_ready, item_xfer;

    assign out_adv   = !out_valid_reg || result.ready;
    assign s2_ready  = !s2_valid_reg || out_adv;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign item.ready = s1_ready;
    assign item_xfer = item.valid && s1_ready;

    // ---- per-item state update ----
    duty_t  min_clamped, ctrl_clamped, manual_scaled, manual_clamped;
    duty_t  duty_raw, duty_round;
    stamp_t since_sample, elapsed;
    logic   sample_due, cycle_due, on_expired;
    prod_t  elapsed_scaled, prod_new, prod_next;
    logic   relay_next;

    assign min_clamped    = (min_duty_reg > FULL_DUTY) ? FULL_DUTY : min_duty_reg;
    assign ctrl_clamped   = (item.ctrl_output > FULL_DUTY) ? FULL_DUTY : item.ctrl_output;
    assign manual_scaled  = {7'd0, manual_pct_reg} * PCT_SCALE;
    assign manual_clamped = (manual_scaled > FULL_DUTY) ? FULL_DUTY : manual_scaled;

    // auto mode samples the controller once per sample period (wrapping time)
    assign since_sample = item.now_ms - last_sample_reg;
    assign sample_due   = !manual_reg && (since_sample >= {18'd0, sample_period_reg});

    always_comb
    begin
        if (manual_reg)
            duty_raw = manual_clamped;
        else if (sample_due)
            duty_raw = ctrl_clamped;
        else
            duty_raw = pending_reg;
    end

    // a small nonzero duty snaps to the minimum or to zero, break at half
    always_comb
    begin
        duty_round = duty_raw;
        if (duty_raw != '0 && duty_raw < min_clamped)
            duty_round = ({duty_raw, 1'b0} >= {1'b0, min_clamped}) ? min_clamped : '0;
    end

    assign elapsed = item.now_ms - cycle_start_reg;

    // elapsed > floor(prod / 10000) is the same as prod < elapsed * 10000;
    // any elapsed of 2^16 or more exceeds every possible on-time
    assign elapsed_scaled = {14'd0, elapsed[15:0]} * FULL_PROD;
    assign on_expired     = (elapsed[31:16] != '0) || (prod_reg < elapsed_scaled);

    assign cycle_due = elapsed > {16'd0, cycle_len_reg};
    assign prod_new  = {16'd0, duty_round} * {14'd0, cycle_len_reg};
    assign prod_next = cycle_due ? prod_new : prod_reg;

    always_comb
    begin
        relay_next = relay_reg && !on_expired;
        // a new cycle with a nonzero on-time turns the relay on
        if (cycle_due && prod_new >= FULL_PROD)
            relay_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_start_reg <= '0;
            last_sample_reg <= '0;
            pending_reg     <= '0;
            prod_reg        <= '0;
            relay_reg       <= 1'b0;
        end
        else if (item_xfer)
        begin
            if (sample_due)
                last_sample_reg <= item.now_ms;
            if (cycle_due)
                cycle_start_reg <= item.now_ms;
            pending_reg <= duty_round;
            prod_reg    <= prod_next;
            relay_reg   <= relay_next;
        end
    end

    // ---- result pipeline valid bits ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= item.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // stage 2: reciprocal estimate of prod / 10000, exact or one low
    logic [46:0] recip_prod;
    assign recip_prod = {17'd0, s1_prod_reg} * {30'd0, RECIP_MULT};

    // stage 3: one remainder check fixes the estimate
    prod_t remainder;
    ms16_t on_time_fixed;
    assign remainder     = s2_prod_reg - ({14'd0, s2_quot_reg} * FULL_PROD);
    assign on_time_fixed = s2_quot_reg + {15'd0, (remainder >= FULL_PROD)};

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            s1_prod_reg                 <= prod_next;
            s1_flags_reg.heater_on      <= relay_next;
            s1_flags_reg.cycle_started  <= cycle_due;
            s1_flags_reg.output_sampled <= sample_due;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_reg  <= s1_prod_reg;
            s2_quot_reg  <= recip_prod[RECIP_SHIFT +: 16];
            s2_flags_reg <= s1_flags_reg;
        end
        if (out_adv && s2_valid_reg)
        begin
            out_on_time_reg <= on_time_fixed;
            out_flags_reg   <= s2_flags_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.heater_on      = out_flags_reg.heater_on;
    assign result.cycle_started  = out_flags_reg.cycle_started;
    assign result.output_sampled = out_flags_reg.output_sampled;
    assign result.on_time_ms     = out_on_time_reg;

    // ---- checks ----

    // a cycle that starts with a nonzero on-time drives the relay on
    a_start_turns_on: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_flags_reg.cycle_started && (s1_prod_reg >= FULL_PROD)
        |-> s1_flags_reg.heater_on)
        else $error("cycle started with nonzero on-time but relay is off");

    // the reciprocal estimate is never more than one low
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (remainder < {FULL_PROD[28:0], 1'b0}))
        else $error("on-time quotient estimate out of range");

    // with the relay off, only a new cycle can turn it on
    a_relay_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && !relay_reg && !cycle_due |=> !relay_reg)
        else $error("relay turned on without a new cycle");

endmodule

FILE: dv/relay_pwm_checker.sv
`timescale 1ns / 1ps
// result checker for the relay time-proportioning pwm: predicts each result and compares it
// depends on rtp_pkg, rtp_in_if, rtp_out_if and rtp_cfg_if
module relay_pwm_checker (
    input  logic clk,
    input  logic rst_n,
    rtp_in_if    item,
    rtp_out_if   result,
    rtp_cfg_if   cfg,
    input  logic end_of_test,
    output int   fail_count,
    output int   outstanding
);
    import rtp_pkg::*;

    typedef struct packed {
        logic  heater_on;
        logic  cycle_started;
        ms16_t on_time_ms;
        logic  output_sampled;
    } relay_outputs_t;

    localparam int PRINT_LIMIT = 40;

    // shadow registers
    ms16_t  cycle_len;
    duty_t  min_duty;
    duty_t  sample_period;
    logic   manual_mode;
    pct_t   manual_power;

    // shadow state
    stamp_t cycle_start;
    ms16_t  on_time;
    logic   relay_on;
    duty_t  duty_pending;
    stamp_t last_sample;

    relay_outputs_t relay_outputs_due[$];
    int             results_seen;
    bit             leftovers_flushed;

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // one timestamp through duty selection, rounding, relay-off and cycle start
    function automatic relay_outputs_t advance_relay(input stamp_t now, input duty_t ctrl);
        relay_outputs_t  r;
        int unsigned     duty_floor;
        int unsigned     duty;
        stamp_t          since_sample;
        stamp_t          elapsed;
        longint unsigned product;
        r            = '0;
        duty_floor   = (min_duty > FULL_DUTY) ? FULL_DUTY : min_duty;
        duty         = duty_pending;
        since_sample = now - last_sample;
        if (!manual_mode) begin
            if (since_sample >= 32'(sample_period)) begin
                last_sample      = now;
                duty             = (ctrl > FULL_DUTY) ? FULL_DUTY : ctrl;
                r.output_sampled = 1'b1;
            end
        end else begin
            duty = manual_power * PCT_SCALE;
            if (duty > FULL_DUTY)
                duty = FULL_DUTY;
        end
        if (duty != 0 && duty < duty_floor)
            duty = (duty * 2 >= duty_floor) ? duty_floor : 0;
        duty_pending = duty_t'(duty);

        elapsed = now - cycle_start;
        if (relay_on && elapsed > 32'(on_time))
            relay_on = 1'b0;
        if (elapsed > 32'(cycle_len)) begin
            cycle_start     = now;
            product         = 64'(duty) * 64'(cycle_len);
            on_time         = ms16_t'(product / 64'(FULL_DUTY));
            r.cycle_started = 1'b1;
            if (on_time != 0)
                relay_on = 1'b1;
        end
        r.heater_on  = relay_on;
        r.on_time_ms = on_time;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        relay_outputs_t got;
        relay_outputs_t want;
        if (!rst_n) begin
            cycle_len     = CYCLE_LENGTH_RST;
            min_duty      = MIN_DUTY_RST;
            sample_period = SAMPLE_PERIOD_RST;
            manual_mode   = 1'b0;
            manual_power  = '0;
            cycle_start   = '0;
            on_time       = '0;
            relay_on      = 1'b0;
            duty_pending  = '0;
            last_sample   = '0;
            relay_outputs_due.delete();
            results_seen      = 0;
            leftovers_flushed = 1'b0;
            fail_count        = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg_index_t'(cfg.index))
                    CFG_CYCLE_LENGTH:  cycle_len     = cfg.data;
                    CFG_MIN_DUTY:      min_duty      = cfg.data[13:0];
                    CFG_SAMPLE_PERIOD: sample_period = cfg.data[13:0];
                    CFG_MANUAL_MODE:   manual_mode   = cfg.data[0];
                    CFG_MANUAL_POWER:  manual_power  = cfg.data[6:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                relay_outputs_due.push_back(advance_relay(item.now_ms, item.ctrl_output));
            if (result.valid && result.ready) begin
                got = {result.heater_on, result.cycle_started, result.on_time_ms,
                       result.output_sampled};
                if (relay_outputs_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                              results_seen));
                end else begin
                    want = relay_outputs_due.pop_front();
                    if (got.heater_on != want.heater_on)
                        report_mismatch($sformatf("result %0d heater_on %0b, predicted %0b",
                                                  results_seen, got.heater_on, want.heater_on));
                    if (got.cycle_started != want.cycle_started)
                        report_mismatch($sformatf("result %0d cycle_started %0b, predicted %0b",
                                                  results_seen, got.cycle_started,
                                                  want.cycle_started));
                    if (got.on_time_ms != want.on_time_ms)
                        report_mismatch($sformatf("result %0d on_time_ms %0d, predicted %0d",
                                                  results_seen, got.on_time_ms,
                                                  want.on_time_ms));
                    if (got.output_sampled != want.output_sampled)
                        report_mismatch($sformatf("result %0d output_sampled %0b, predicted %0b",
                                                  results_seen, got.output_sampled,
                                                  want.output_sampled));
                end
                results_seen++;
            end
            if (end_of_test && !leftovers_flushed) begin
                leftovers_flushed = 1'b1;
                while (relay_outputs_due.size() != 0) begin
                    want = relay_outputs_due.pop_front();
                    report_mismatch("predicted result never arrived");
                end
            end
        end
        outstanding = relay_outputs_due.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// top of the relay time-proportioning pwm testbench: clock, reset, stimulus, verdict
// depends on rtp_pkg, the channel interfaces, the block and relay_pwm_checker
module testbench;
    import rtp_pkg::*;

    typedef struct packed {
        ms16_t cycle_len;
        duty_t min_duty;
        duty_t sample_period;
        logic  manual_mode;
        pct_t  manual_power;
    } setting_t;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 54;
    localparam int DIRECTED        = 20;
    localparam int DRAIN_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DUTY_MAX        = (1 << $bits(duty_t)) - 1;

    // register settings per phase; the idle pattern follows the phase number:
    // none, sender gaps, receiver stalls, both
    localparam setting_t PLAN [PHASES] = '{
        '{16'd1000,  14'd0,     14'd1,     1'b0, 7'd0},    // cycle of 1000, no min duty
        '{16'd60000, 14'd10000, 14'd10000, 1'b0, 7'd100},  // cycle of 60000, full min duty, period 10000
        '{16'd0,     14'd16383, 14'd0,     1'b0, 7'd50},   // zero cycle, min duty over full
        '{16'd65535, 14'd1,     14'd16383, 1'b1, 7'd127},  // manual power over 100 percent
        '{16'd5000,  14'd500,   14'd100,   1'b1, 7'd3},    // manual 3 percent rounds up
        '{16'd2500,  14'd3000,  14'd250,   1'b0, 7'd2},
        '{16'd1000,  14'd600,   14'd0,     1'b1, 7'd2},    // manual 2 percent rounds down
        '{16'd10000, 14'd500,   14'd100,   1'b0, 7'd0}     // back to reset values
    };

    // directed stamps, run on the reset settings (cycle 10000, min duty 500, period 100)
    localparam stamp_t DIRECTED_NOW [DIRECTED] = '{
        32'd0,          32'd150,        32'd10001,      32'd10002,
        32'd10200,      32'd10300,      32'd10400,      32'd10500,
        32'd20001,      32'd20002,      32'd25002,      32'd25003,
        32'd30003,      32'hFFFF_FF00,  32'h0000_0010,  32'h0000_2720,
        32'h0000_2710,  32'hFFFF_FFFF,  32'h8000_0000,  32'h7FFF_FFFF
    };
    localparam duty_t DIRECTED_CTRL [DIRECTED] = '{
        14'd0,     14'd16383, 14'd10000, 14'd200,
        14'd200,   14'd250,   14'd249,   14'd5000,
        14'd5000,  14'd5000,  14'd0,     14'd0,
        14'd1,     14'd10000, 14'd10000, 14'd3,
        14'd9999,  14'd16383, 14'd10000, 14'd1
    };

    logic   clk;
    logic   rst_n;
    logic   end_of_test;
    int     fail_count;
    int     outstanding;
    int     idle_cycles = 0;
    int     items_sent  = 0;
    int     sender_gap_pct;
    int     receiver_stall_pct;
    stamp_t wall_ms;

    rtp_in_if  item_if ();
    rtp_out_if result_if ();
    rtp_cfg_if cfg_if ();

    relay_time_proportioning_pwm_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .cfg    (cfg_if),
        .result (result_if)
    );

    relay_pwm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_if),
        .result      (result_if),
        .cfg         (cfg_if),
        .end_of_test (end_of_test),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: ready drops at random while a stall pattern is active
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge clk) begin
        if (!rst_n || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input transfer; an optional gap first, valid stays high into the next call
    task automatic send_item(input stamp_t now, input duty_t ctrl);
        if ($urandom_range(0, 99) < sender_gap_pct) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < sender_gap_pct)
                @(posedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.now_ms      <= now;
        item_if.ctrl_output <= ctrl;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // one register write transfer; the caller lowers valid after the last one
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    // stop sending, wait for every predicted result, then let the pipeline empty
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int unsigned pick;
        int unsigned delta;
        int unsigned duty_floor;
        duty_t       ctrl;

        rst_n               = 1'b0;
        end_of_test         = 1'b0;
        item_if.valid       = 1'b0;
        item_if.now_ms      = '0;
        item_if.ctrl_output = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_CYCLE_LENGTH;
        cfg_if.data         = '0;
        sender_gap_pct      = 0;
        receiver_stall_pct  = 0;
        wall_ms             = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset settings: clamping above full scale, rounding at half the
        // min duty, relay off past the on-time, zero on-time at a cycle start,
        // timestamps across the wrap and stepping backward
        for (int i = 0; i < DIRECTED; i++)
            send_item(DIRECTED_NOW[i], DIRECTED_CTRL[i]);

        for (int k = 0; k < PHASES; k++) begin
            // registers change only with nothing in flight
            settle();
            write_reg(CFG_CYCLE_LENGTH,  16'(PLAN[k].cycle_len));
            write_reg(CFG_MIN_DUTY,      16'(PLAN[k].min_duty));
            write_reg(CFG_SAMPLE_PERIOD, 16'(PLAN[k].sample_period));
            write_reg(CFG_MANUAL_MODE,   16'(PLAN[k].manual_mode));
            write_reg(CFG_MANUAL_POWER,  16'(PLAN[k].manual_power));
            cfg_if.valid <= 1'b0;

            case (k % 4)
                0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_gap_pct = 56; receiver_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  receiver_stall_pct = 56; end
                default: begin sender_gap_pct = 35; receiver_stall_pct = 35; end
            endcase

            // one phase starts just below the wrap of the millisecond counter
            if (k == 2)
                wall_ms = 32'hFFFF_0000 + $urandom_range(0, 65535);

            duty_floor = (PLAN[k].min_duty > FULL_DUTY) ? FULL_DUTY : PLAN[k].min_duty;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // time mostly moves forward in steps around the sample period and
                // the cycle length, with rare jumps anywhere and short backward steps
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    delta = $urandom_range(0, 2 * PLAN[k].sample_period + 1);
                else if (pick < 85)
                    delta = $urandom_range(0, PLAN[k].cycle_len / 4 + 1);
                else if (pick < 92)
                    delta = PLAN[k].cycle_len + $urandom_range(0, 2);
                else if (pick < 97)
                    delta = $urandom;
                else
                    delta = 0 - $urandom_range(1, 1000);
                wall_ms = wall_ms + delta;

                // controller output: mostly in range, often near the min duty, some at
                // the ends and some above full scale
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    ctrl = duty_t'($urandom_range(0, FULL_DUTY));
                else if (pick < 80)
                    ctrl = duty_t'($urandom_range(0, duty_floor + duty_floor / 2 + 1));
                else if (pick < 92)
                    ctrl = pick[0] ? FULL_DUTY : '0;
                else
                    ctrl = duty_t'($urandom_range(FULL_DUTY + 1, DUTY_MAX));
                send_item(wall_ms, ctrl);
            end
        end

        settle();
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);

        $display("run covered %0d input transfers: %0d directed, then %0d register settings",
                 items_sent, DIRECTED, PHASES);
        $display("with auto and manual duty, timestamp wraps, backward steps and idle patterns");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rtp_pkg.sv
sv/rtp_in_if.sv
sv/rtp_out_if.sv
sv/rtp_cfg_if.sv
sv/relay_time_proportioning_pwm_top.sv
dv/relay_pwm_checker.sv
dv/testbench.sv
